FILE: sv/emr_pkg.sv
// Shared types and constants for the midpoint ellipse rasterizer.
// No dependencies; every other file in the block but emr_mul refers to this package by scoped name.
package emr_pkg;

    // default operand widths
    localparam int RADIUS_BITS_DEF = 10;
    localparam int COORD_BITS_DEF  = 12;

    // number of words held between the front and the back
    localparam int QUEUE_DEPTH = 2;

    // command class decoded by the front
    typedef enum logic {
        CMD_START = 1'b0,
        CMD_STEP  = 1'b1
    } cmd_kind_t;

    // drawing phase of the current ellipse
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ONE,
        PH_TWO
    } phase_t;

    // back-end sequencer states
    typedef enum logic [3:0] {
        BK_IDLE,
        BK_ST1,
        BK_ST2,
        BK_ST3,
        BK_ST4,
        BK_ST5,
        BK_TR1,
        BK_TR2,
        BK_TR3,
        BK_TR4,
        BK_TR5,
        BK_TR6,
        BK_EMIT
    } back_state_t;

endpackage

FILE: sv/emr_front.sv
// Front end of the rasterizer: input register stage that decodes the command class.
// Depends on emr_pkg; feeds emr_queue.
module emr_front #(
    parameter int RADIUS_BITS = emr_pkg::RADIUS_BITS_DEF,
    parameter int COORD_BITS  = emr_pkg::COORD_BITS_DEF
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            s_valid,
    output logic                                            s_ready,
    input  logic [((2*RADIUS_BITS+2*COORD_BITS+7)/8)*8-1:0] s_data,
    input  logic                                            s_user,
    output logic                                            q_valid,
    input  logic                                            q_ready,
    output logic [2*RADIUS_BITS+2*COORD_BITS:0]             q_entry
);

    localparam int FIELD_W = 2*RADIUS_BITS + 2*COORD_BITS;
    localparam int ENTRY_W = FIELD_W + 1;

    emr_pkg::cmd_kind_t   kind;
    logic [ENTRY_W-1:0]   entry_next;
    logic [ENTRY_W-1:0]   entry_reg;
    logic                 valid_reg;

    // decode the command class and pack the entry, class in bit 0
    always_comb
    begin
        kind       = s_user ? emr_pkg::CMD_STEP : emr_pkg::CMD_START;
        entry_next = {s_data[FIELD_W-1:0], logic'(kind)};
    end

    // stage takes a new word whenever it is empty or draining
    assign s_ready = !valid_reg || q_ready;
    assign q_valid = valid_reg;
    assign q_entry = entry_reg;

    // stage valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_ready)
        begin
            valid_reg <= s_valid;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (s_valid && s_ready)
        begin
            entry_reg <= entry_next;
        end
    end

endmodule

FILE: sv/emr_queue.sv
// Short first-in first-out queue that decouples the front end from the back end.
// Depends on emr_pkg for its depth.
module emr_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int DEPTH = emr_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // pointer wrap and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

FILE: sv/emr_mul.sv
// Shared unsigned multiplier with a registered product.
// No dependencies; used by emr_back for squares and decision terms.
module emr_mul #(
    parameter int A_W = 20,
    parameter int B_W = 22
) (
    input  logic               clk,
    input  logic [A_W-1:0]     a,
    input  logic [B_W-1:0]     b,
    output logic [A_W+B_W-1:0] prod
);

    logic [A_W+B_W-1:0] prod_reg;

    // one product per cycle, ready in the cycle after its operands are applied
    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

FILE: sv/emr_back.sv
// Back end of the rasterizer: sequencer that runs start, iteration and transition steps,
// drives the shared multiplier and the output register. Depends on emr_pkg and emr_mul.
module emr_back #(
    parameter int RADIUS_BITS = emr_pkg::RADIUS_BITS_DEF,
    parameter int COORD_BITS  = emr_pkg::COORD_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_valid,
    output logic                                q_ready,
    input  logic [2*RADIUS_BITS+2*COORD_BITS:0] q_entry,
    output logic                                res_valid,
    input  logic                                res_ready,
    output logic [COORD_BITS:0]                 res_x,
    output logic [COORD_BITS:0]                 res_y,
    output logic                                res_last,
    output logic                                res_done
);

    localparam int R      = RADIUS_BITS;
    localparam int C      = COORD_BITS;
    localparam int SQ_W   = 2*R;
    localparam int AX_W   = 3*R;
    localparam int MA_W   = 2*R;
    localparam int MB_W   = 2*R + 2;
    localparam int P_W    = MA_W + MB_W;
    localparam int DEC_W  = 4*R + 8;
    localparam int PT_W   = C + 1;
    localparam int SUM_W  = ((C > R) ? C : R) + 2;
    localparam int RX_LO  = 1;
    localparam int RY_LO  = 1 + R;
    localparam int CX_LO  = 1 + 2*R;
    localparam int CY_LO  = 1 + 2*R + C;

    // queue entry fields
    emr_pkg::cmd_kind_t q_kind;
    logic [R-1:0]       q_rx;
    logic [R-1:0]       q_ry;
    logic [C-1:0]       q_cx;
    logic [C-1:0]       q_cy;

    // sequencer and geometry state
    emr_pkg::back_state_t state_reg, state_next;
    emr_pkg::phase_t      phase_reg, phase_next;
    logic [R-1:0]         x_reg, x_next;
    logic [R-1:0]         y_reg, y_next;
    logic [R-1:0]         rx_reg, rx_next;
    logic [AX_W-1:0]      ax_reg, ax_next;
    logic [AX_W-1:0]      ay_reg, ay_next;
    logic signed [DEC_W-1:0] d_reg, d_next;
    logic [SQ_W-1:0]      rx2_reg, rx2_next;
    logic [SQ_W-1:0]      ry2_reg, ry2_next;
    logic [C-1:0]         cx_reg, cx_next;
    logic [C-1:0]         cy_reg, cy_next;
    logic [1:0]           cnt_reg, cnt_next;
    logic                 single_reg, single_next;
    logic                 fin_reg, fin_next;
    logic                 upd_reg, upd_next;
    logic                 upd_r1_reg, upd_r1_next;
    logic                 upd_a_reg, upd_a_next;
    logic                 upd_b_reg, upd_b_next;

    // output register
    logic                 ov_reg;
    logic [PT_W-1:0]      ox_reg;
    logic [PT_W-1:0]      oy_reg;
    logic                 olast_reg;
    logic                 odone_reg;
    logic                 out_free;
    logic                 out_load;
    logic                 last_now;
    logic                 done_now;

    // multiplier
    logic [MA_W-1:0]      mul_a;
    logic [MB_W-1:0]      mul_b;
    logic [P_W-1:0]       prod;

    // datapath helpers
    logic [AX_W-1:0]         ry2_ax;
    logic [AX_W-1:0]         rx2_ax;
    logic [R:0]              tx;
    logic [R-1:0]            ym1;
    logic signed [DEC_W-1:0] ax8;
    logic signed [DEC_W-1:0] ay8;
    logic signed [DEC_W-1:0] sq4;
    logic signed [DEC_W-1:0] ry2_4;
    logic signed [DEC_W-1:0] rx2_d;
    logic signed [DEC_W-1:0] prod_d;
    logic signed [DEC_W-1:0] prod4;
    logic signed [DEC_W-1:0] d_upd;
    logic                    d_neg;
    logic signed [SUM_W-1:0] cx_ext;
    logic signed [SUM_W-1:0] cy_ext;
    logic signed [SUM_W-1:0] xo_ext;
    logic signed [SUM_W-1:0] yo_ext;
    logic signed [SUM_W-1:0] pt_x;
    logic signed [SUM_W-1:0] pt_y;

    assign q_kind = emr_pkg::cmd_kind_t'(q_entry[0]);
    assign q_rx   = q_entry[RX_LO +: R];
    assign q_ry   = q_entry[RY_LO +: R];
    assign q_cx   = q_entry[CX_LO +: C];
    assign q_cy   = q_entry[CY_LO +: C];

    assign q_ready = (state_reg == emr_pkg::BK_IDLE);

    emr_mul #(
        .A_W (MA_W),
        .B_W (MB_W)
    ) u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // operand extensions and the pending decision update
    always_comb
    begin
        ry2_ax = {{(AX_W-SQ_W){1'b0}}, ry2_reg};
        rx2_ax = {{(AX_W-SQ_W){1'b0}}, rx2_reg};
        tx     = {x_reg, 1'b1};
        ym1    = (y_reg == '0) ? R'(1) : y_reg - R'(1);
        ax8    = {{(DEC_W-AX_W-3){1'b0}}, ax_reg, 3'b000};
        ay8    = {{(DEC_W-AX_W-3){1'b0}}, ay_reg, 3'b000};
        sq4    = {{(DEC_W-SQ_W-2){1'b0}}, (upd_r1_reg ? ry2_reg : rx2_reg), 2'b00};
        ry2_4  = {{(DEC_W-SQ_W-2){1'b0}}, ry2_reg, 2'b00};
        rx2_d  = {{(DEC_W-SQ_W){1'b0}}, rx2_reg};
        prod_d = {{(DEC_W-P_W){1'b0}}, prod};
        prod4  = {{(DEC_W-P_W-2){1'b0}}, prod, 2'b00};
        d_upd  = d_reg + (upd_a_reg ? ax8 : '0) + sq4 - (upd_b_reg ? ay8 : '0);
        d_neg  = d_reg[DEC_W-1];
    end

    // mirrored point: count bit 0 flips x, bit 1 flips y
    always_comb
    begin
        cx_ext   = {{(SUM_W-C){cx_reg[C-1]}}, cx_reg};
        cy_ext   = {{(SUM_W-C){cy_reg[C-1]}}, cy_reg};
        xo_ext   = {{(SUM_W-R){1'b0}}, x_reg};
        yo_ext   = {{(SUM_W-R){1'b0}}, y_reg};
        pt_x     = cnt_reg[0] ? cx_ext - xo_ext : cx_ext + xo_ext;
        pt_y     = cnt_reg[1] ? cy_ext - yo_ext : cy_ext + yo_ext;
        last_now = single_reg || (cnt_reg == 2'd3);
        done_now = last_now && fin_reg;
        out_free = !ov_reg || res_ready;
    end

    // sequencer next state
    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        rx_next     = rx_reg;
        ax_next     = ax_reg;
        ay_next     = ay_reg;
        d_next      = d_reg;
        rx2_next    = rx2_reg;
        ry2_next    = ry2_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        cnt_next    = cnt_reg;
        single_next = single_reg;
        fin_next    = fin_reg;
        upd_next    = upd_reg;
        upd_r1_next = upd_r1_reg;
        upd_a_next  = upd_a_reg;
        upd_b_next  = upd_b_reg;
        mul_a       = '0;
        mul_b       = '0;
        out_load    = 1'b0;
        case (state_reg)
            emr_pkg::BK_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_kind == emr_pkg::CMD_START)
                    begin
                        // latch operands, squares follow on the multiplier
                        rx_next    = q_rx;
                        x_next     = '0;
                        y_next     = q_ry;
                        ax_next    = '0;
                        cx_next    = q_cx;
                        cy_next    = q_cy;
                        phase_next = emr_pkg::PH_ONE;
                        state_next = emr_pkg::BK_ST1;
                    end
                    else
                    begin
                        case (phase_reg)
                            emr_pkg::PH_ONE:
                            begin
                                if (ax_reg < ay_reg)
                                begin
                                    // region one step
                                    x_next  = x_reg + R'(1);
                                    ax_next = ax_reg + ry2_ax;
                                    if (!d_neg)
                                    begin
                                        y_next  = y_reg - R'(1);
                                        ay_next = ay_reg - rx2_ax;
                                    end
                                    upd_next    = 1'b1;
                                    upd_r1_next = 1'b1;
                                    upd_a_next  = 1'b1;
                                    upd_b_next  = !d_neg;
                                    single_next = 1'b0;
                                    fin_next    = 1'b0;
                                    cnt_next    = 2'd0;
                                    state_next  = emr_pkg::BK_EMIT;
                                end
                                else
                                begin
                                    state_next = emr_pkg::BK_TR1;
                                end
                            end
                            emr_pkg::PH_TWO:
                            begin
                                if (y_reg != '0)
                                begin
                                    // region two step
                                    y_next  = y_reg - R'(1);
                                    ay_next = ay_reg - rx2_ax;
                                    if (d_neg || d_reg == '0)
                                    begin
                                        x_next  = x_reg + R'(1);
                                        ax_next = ax_reg + ry2_ax;
                                    end
                                    upd_next    = 1'b1;
                                    upd_r1_next = 1'b0;
                                    upd_a_next  = d_neg || (d_reg == '0);
                                    upd_b_next  = 1'b1;
                                    single_next = 1'b0;
                                    fin_next    = (y_reg == R'(1));
                                    if (y_reg == R'(1))
                                    begin
                                        phase_next = emr_pkg::PH_IDLE;
                                    end
                                    cnt_next    = 2'd0;
                                    state_next  = emr_pkg::BK_EMIT;
                                end
                                else
                                begin
                                    phase_next = emr_pkg::PH_IDLE;
                                end
                            end
                            default:
                            begin
                                // nothing to draw
                            end
                        endcase
                    end
                end
            end
            emr_pkg::BK_ST1:
            begin
                mul_a      = MA_W'(rx_reg);
                mul_b      = MB_W'(rx_reg);
                state_next = emr_pkg::BK_ST2;
            end
            emr_pkg::BK_ST2:
            begin
                rx2_next   = prod[SQ_W-1:0];
                mul_a      = MA_W'(y_reg);
                mul_b      = MB_W'(y_reg);
                state_next = emr_pkg::BK_ST3;
            end
            emr_pkg::BK_ST3:
            begin
                ry2_next   = prod[SQ_W-1:0];
                d_next     = rx2_d;
                mul_a      = rx2_reg;
                mul_b      = MB_W'(y_reg);
                state_next = emr_pkg::BK_ST4;
            end
            emr_pkg::BK_ST4:
            begin
                // rx2*ry is also the initial rx2*y
                ay_next    = prod[AX_W-1:0];
                d_next     = d_reg - prod4;
                state_next = emr_pkg::BK_ST5;
            end
            emr_pkg::BK_ST5:
            begin
                d_next      = d_reg + ry2_4;
                upd_next    = 1'b0;
                single_next = 1'b1;
                fin_next    = 1'b0;
                cnt_next    = 2'd0;
                state_next  = emr_pkg::BK_EMIT;
            end
            emr_pkg::BK_TR1:
            begin
                mul_a      = MA_W'(tx);
                mul_b      = MB_W'(tx);
                state_next = emr_pkg::BK_TR2;
            end
            emr_pkg::BK_TR2:
            begin
                mul_a      = ry2_reg;
                mul_b      = prod[MB_W-1:0];
                state_next = emr_pkg::BK_TR3;
            end
            emr_pkg::BK_TR3:
            begin
                d_next     = prod_d;
                mul_a      = MA_W'(ym1);
                mul_b      = MB_W'(ym1);
                state_next = emr_pkg::BK_TR4;
            end
            emr_pkg::BK_TR4:
            begin
                mul_a      = rx2_reg;
                mul_b      = prod[MB_W-1:0];
                state_next = emr_pkg::BK_TR5;
            end
            emr_pkg::BK_TR5:
            begin
                d_next     = d_reg + prod4;
                mul_a      = rx2_reg;
                mul_b      = MB_W'(ry2_reg);
                state_next = emr_pkg::BK_TR6;
            end
            emr_pkg::BK_TR6:
            begin
                // region two decision ready, one unmirrored point
                d_next      = d_reg - prod4;
                fin_next    = (y_reg == '0);
                phase_next  = (y_reg == '0) ? emr_pkg::PH_IDLE : emr_pkg::PH_TWO;
                upd_next    = 1'b0;
                single_next = 1'b1;
                cnt_next    = 2'd0;
                state_next  = emr_pkg::BK_EMIT;
            end
            emr_pkg::BK_EMIT:
            begin
                if (upd_reg)
                begin
                    d_next   = d_upd;
                    upd_next = 1'b0;
                end
                if (out_free)
                begin
                    out_load = 1'b1;
                    cnt_next = cnt_reg + 2'd1;
                    if (last_now)
                    begin
                        state_next = emr_pkg::BK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = emr_pkg::BK_IDLE;
            end
        endcase
    end

    // sequencer and geometry registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= emr_pkg::BK_IDLE;
            phase_reg  <= emr_pkg::PH_IDLE;
            x_reg      <= '0;
            y_reg      <= '0;
            rx_reg     <= '0;
            ax_reg     <= '0;
            ay_reg     <= '0;
            d_reg      <= '0;
            rx2_reg    <= '0;
            ry2_reg    <= '0;
            cx_reg     <= '0;
            cy_reg     <= '0;
            cnt_reg    <= '0;
            single_reg <= 1'b0;
            fin_reg    <= 1'b0;
            upd_reg    <= 1'b0;
            upd_r1_reg <= 1'b0;
            upd_a_reg  <= 1'b0;
            upd_b_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
            rx_reg     <= rx_next;
            ax_reg     <= ax_next;
            ay_reg     <= ay_next;
            d_reg      <= d_next;
            rx2_reg    <= rx2_next;
            ry2_reg    <= ry2_next;
            cx_reg     <= cx_next;
            cy_reg     <= cy_next;
            cnt_reg    <= cnt_next;
            single_reg <= single_next;
            fin_reg    <= fin_next;
            upd_reg    <= upd_next;
            upd_r1_reg <= upd_r1_next;
            upd_a_reg  <= upd_a_next;
            upd_b_reg  <= upd_b_next;
        end
    end

    // output word valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (out_free)
        begin
            ov_reg <= out_load;
        end
    end

    // output word payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            ox_reg    <= pt_x[PT_W-1:0];
            oy_reg    <= pt_y[PT_W-1:0];
            olast_reg <= last_now;
            odone_reg <= done_now;
        end
    end

    assign res_valid = ov_reg;
    assign res_x     = ox_reg;
    assign res_y     = oy_reg;
    assign res_last  = olast_reg;
    assign res_done  = odone_reg;

    // a step that does nothing leaves the decision alone
    a_idle_keeps_decision: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == emr_pkg::BK_IDLE && $past(state_reg) == emr_pkg::BK_IDLE)
        |-> $stable(d_reg))
        else $error("decision changed while the sequencer stayed idle");

    // coordinates hold while a point group goes out
    a_emit_holds_coords: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == emr_pkg::BK_EMIT && $past(state_reg) == emr_pkg::BK_EMIT)
        |-> ($stable(x_reg) && $stable(y_reg)))
        else $error("offsets moved during point output");

    // the completion flag only goes out once the ellipse is closed
    a_done_means_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == emr_pkg::BK_EMIT && out_load && done_now)
        |-> (phase_reg == emr_pkg::PH_IDLE))
        else $error("done flagged while the ellipse is still open");

    // a single point group keeps its count at zero while it is emitted
    a_single_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == emr_pkg::BK_EMIT && single_reg) |-> (cnt_reg == 2'd0))
        else $error("single point group emitted more than one word");

endmodule

FILE: sv/midpoint_ellipse_rasterizer_top.sv
// Top level of the midpoint ellipse rasterizer: front stage, queue and back-end sequencer.
// Depends on emr_pkg, emr_front, emr_queue, emr_mul and emr_back.
//
// A start word (tuser low) loads radii and centre and produces the top point of the ellipse;
// each advance word (tuser high) runs one midpoint iteration and produces four mirrored
// points, or the single transition point where region one ends; advance words after the
// ellipse is done produce nothing. Input words pass a register stage and a two-word queue,
// so the input side keeps accepting while the back end works. An advance word is dispatched
// from idle, then its points go out one per cycle through the output register while the
// output side is ready; a start runs BK_ST1 to BK_ST5 and a transition BK_TR1 to BK_TR6,
// with their passes through the single shared radius-squared by (2*RADIUS_BITS+2)-bit
// multiplier. Output stalls hold the sequencer in BK_EMIT. tlast marks the last point of
// each input word and tuser marks the point that completes the ellipse.
module midpoint_ellipse_rasterizer_top #(
    parameter int RADIUS_BITS = emr_pkg::RADIUS_BITS_DEF,
    parameter int COORD_BITS  = emr_pkg::COORD_BITS_DEF
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            s_axis_tvalid,
    output logic                                            s_axis_tready,
    // radius_x, radius_y, centre_x, centre_y from bit 0 up, zero padded
    input  logic [((2*RADIUS_BITS+2*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    // action
    input  logic                                            s_axis_tuser,
    output logic                                            m_axis_tvalid,
    input  logic                                            m_axis_tready,
    // point_x, point_y from bit 0 up, zero padded
    output logic [((2*COORD_BITS+2+7)/8)*8-1:0]             m_axis_tdata,
    output logic                                            m_axis_tlast,
    // done_res
    output logic                                            m_axis_tuser
);

    localparam int ENTRY_W = 2*RADIUS_BITS + 2*COORD_BITS + 1;
    localparam int OUT_W   = ((2*COORD_BITS+2+7)/8)*8;

    logic               fq_valid;
    logic               fq_ready;
    logic [ENTRY_W-1:0] fq_entry;
    logic               qb_valid;
    logic               qb_ready;
    logic [ENTRY_W-1:0] qb_entry;
    logic [COORD_BITS:0] point_x;
    logic [COORD_BITS:0] point_y;

    // input stage
    emr_front #(
        .RADIUS_BITS (RADIUS_BITS),
        .COORD_BITS  (COORD_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .s_data  (s_axis_tdata),
        .s_user  (s_axis_tuser),
        .q_valid (fq_valid),
        .q_ready (fq_ready),
        .q_entry (fq_entry)
    );

    // decoupling queue
    emr_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_entry),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_entry)
    );

    // sequencer and output register
    emr_back #(
        .RADIUS_BITS (RADIUS_BITS),
        .COORD_BITS  (COORD_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (qb_valid),
        .q_ready   (qb_ready),
        .q_entry   (qb_entry),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res_x     (point_x),
        .res_y     (point_y),
        .res_last  (m_axis_tlast),
        .res_done  (m_axis_tuser)
    );

    // pack the output word
    assign m_axis_tdata = OUT_W'({point_y, point_x});

endmodule

FILE: test/emr_checker.sv
`timescale 1ns / 100ps
// emr_checker: watches both stream channels of the ellipse rasterizer, predicts the pixel
// words from every accepted input word and compares them in order of arrival
// depends on emr_pkg for the command and phase encodings
module emr_checker #(
    parameter int RADIUS_BITS = emr_pkg::RADIUS_BITS_DEF,
    parameter int COORD_BITS  = emr_pkg::COORD_BITS_DEF
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            s_axis_tvalid,
    input  logic                                            s_axis_tready,
    // radius_x, radius_y, centre_x, centre_y from bit 0 up, zero padded
    input  logic [((2*RADIUS_BITS+2*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    // action
    input  logic                                            s_axis_tuser,
    input  logic                                            m_axis_tvalid,
    input  logic                                            m_axis_tready,
    // point_x, point_y from bit 0 up, zero padded
    input  logic [((2*COORD_BITS+2+7)/8)*8-1:0]             m_axis_tdata,
    input  logic                                            m_axis_tlast,
    // done_res
    input  logic                                            m_axis_tuser,
    output int                                              fail_count,
    output int                                              outstanding,
    output bit                                              drawing,
    output int                                              points_checked,
    output int                                              ellipses_done
);

    localparam int PW   = COORD_BITS + 1;
    localparam int IN_W = ((2*RADIUS_BITS+2*COORD_BITS+7)/8)*8;

    typedef struct packed {
        logic [PW-1:0] px;
        logic [PW-1:0] py;
        logic          last;
        logic          done;
    } pixel_t;

    pixel_t expected_pixels[$];
    pixel_t want_pixel;

    // predicted rasterizer state
    logic [RADIUS_BITS-1:0] ofs_x;
    logic [RADIUS_BITS-1:0] ofs_y;
    logic [63:0]            decision_x4;
    logic [63:0]            rx_sq;
    logic [63:0]            ry_sq;
    logic signed [63:0]     cx_held;
    logic signed [63:0]     cy_held;
    emr_pkg::phase_t        phase;

    function automatic logic [63:0] widen(input logic [RADIUS_BITS-1:0] v);
        return {{(64-RADIUS_BITS){1'b0}}, v};
    endfunction

    task automatic report_mismatch(input string what);
        $display("emr_checker: %0t ns: %s", $time, what);
        fail_count++;
    endtask

    task automatic queue_pixel(input logic signed [63:0] px, input logic signed [63:0] py,
                               input logic last, input logic done);
        pixel_t p;
        p.px   = px[PW-1:0];
        p.py   = py[PW-1:0];
        p.last = last;
        p.done = done;
        expected_pixels.push_back(p);
    endtask

    // four points mirrored about the centre, last one flagged
    task automatic queue_mirrors(input logic done);
        logic signed [63:0] dx;
        logic signed [63:0] dy;
        dx = widen(ofs_x);
        dy = widen(ofs_y);
        queue_pixel(cx_held + dx, cy_held + dy, 1'b0, 1'b0);
        queue_pixel(cx_held - dx, cy_held + dy, 1'b0, 1'b0);
        queue_pixel(cx_held + dx, cy_held - dy, 1'b0, 1'b0);
        queue_pixel(cx_held - dx, cy_held - dy, 1'b1, done);
    endtask

    // one input word: update the state and queue the points it must produce
    task automatic predict_pixels(input logic action, input logic [IN_W-1:0] data);
        logic [RADIUS_BITS-1:0] rx;
        logic [RADIUS_BITS-1:0] ry;
        logic [COORD_BITS-1:0]  cxf;
        logic [COORD_BITS-1:0]  cyf;
        logic [63:0]            tx;
        logic [63:0]            ym1;
        logic                   fin;
        if (action == emr_pkg::CMD_START)
        begin
            // new ellipse, any ellipse in progress is dropped
            rx  = data[RADIUS_BITS-1:0];
            ry  = data[2*RADIUS_BITS-1:RADIUS_BITS];
            cxf = data[2*RADIUS_BITS+COORD_BITS-1:2*RADIUS_BITS];
            cyf = data[2*RADIUS_BITS+2*COORD_BITS-1:2*RADIUS_BITS+COORD_BITS];
            cx_held     = {{(64-COORD_BITS){cxf[COORD_BITS-1]}}, cxf};
            cy_held     = {{(64-COORD_BITS){cyf[COORD_BITS-1]}}, cyf};
            rx_sq       = widen(rx) * widen(rx);
            ry_sq       = widen(ry) * widen(ry);
            ofs_x       = '0;
            ofs_y       = ry;
            decision_x4 = 64'd4 * ry_sq - 64'd4 * rx_sq * widen(ry) + rx_sq;
            phase       = emr_pkg::PH_ONE;
            queue_pixel(cx_held, cy_held + widen(ry), 1'b1, 1'b0);
        end
        else if (phase == emr_pkg::PH_ONE)
        begin
            if (ry_sq * widen(ofs_x) < rx_sq * widen(ofs_y))
            begin
                // region one: x always moves, y drops when the midpoint lies outside
                ofs_x = ofs_x + 1'b1;
                if (!decision_x4[63])
                begin
                    ofs_y       = ofs_y - 1'b1;
                    decision_x4 = decision_x4 - 64'd8 * widen(ofs_y) * rx_sq;
                end
                decision_x4 = decision_x4 + 64'd8 * ry_sq * widen(ofs_x) + 64'd4 * ry_sq;
                queue_mirrors(1'b0);
            end
            else
            begin
                // transition: region-two decision and a single unmirrored point
                tx  = 64'd2 * widen(ofs_x) + 64'd1;
                ym1 = (ofs_y == '0) ? 64'd1 : widen(ofs_y) - 64'd1;
                fin = (ofs_y == '0);
                decision_x4 = ry_sq * tx * tx + 64'd4 * rx_sq * ym1 * ym1
                            - 64'd4 * rx_sq * ry_sq;
                phase = fin ? emr_pkg::PH_IDLE : emr_pkg::PH_TWO;
                queue_pixel(cx_held + widen(ofs_x), cy_held + widen(ofs_y), 1'b1, fin);
                if (fin)
                    ellipses_done++;
            end
        end
        else if (phase == emr_pkg::PH_TWO)
        begin
            if (ofs_y == '0)
                phase = emr_pkg::PH_IDLE;
            else
            begin
                // region two: y always drops, x moves when the midpoint lies inside
                ofs_y = ofs_y - 1'b1;
                if (decision_x4[63] || decision_x4 == '0)
                begin
                    ofs_x       = ofs_x + 1'b1;
                    decision_x4 = decision_x4 + 64'd8 * ry_sq * widen(ofs_x);
                end
                decision_x4 = decision_x4 + 64'd4 * rx_sq - 64'd8 * widen(ofs_y) * rx_sq;
                fin = (ofs_y == '0);
                if (fin)
                begin
                    phase = emr_pkg::PH_IDLE;
                    ellipses_done++;
                end
                queue_mirrors(fin);
            end
        end
        // advance while idle changes nothing
    endtask

    // watch both channels at every edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ofs_x       = '0;
            ofs_y       = '0;
            decision_x4 = '0;
            rx_sq       = '0;
            ry_sq       = '0;
            cx_held     = '0;
            cy_held     = '0;
            phase       = emr_pkg::PH_IDLE;
            expected_pixels.delete();
            outstanding <= 0;
            drawing     <= 1'b0;
        end
        else
        begin
            // result side first, a point at this edge never stems from a word taken at it
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_pixels.size() == 0)
                    report_mismatch($sformatf("point (%0d,%0d) arrived with none expected",
                                    $signed(m_axis_tdata[PW-1:0]),
                                    $signed(m_axis_tdata[2*PW-1:PW])));
                else
                begin
                    want_pixel = expected_pixels.pop_front();
                    if (m_axis_tdata[PW-1:0] !== want_pixel.px)
                        report_mismatch($sformatf("point %0d: point_x %0d, want %0d",
                                        points_checked, $signed(m_axis_tdata[PW-1:0]),
                                        $signed(want_pixel.px)));
                    if (m_axis_tdata[2*PW-1:PW] !== want_pixel.py)
                        report_mismatch($sformatf("point %0d: point_y %0d, want %0d",
                                        points_checked, $signed(m_axis_tdata[2*PW-1:PW]),
                                        $signed(want_pixel.py)));
                    if (m_axis_tlast !== want_pixel.last)
                        report_mismatch($sformatf("point %0d: last %b, want %b",
                                        points_checked, m_axis_tlast, want_pixel.last));
                    if (m_axis_tuser !== want_pixel.done)
                        report_mismatch($sformatf("point %0d: done %b, want %b",
                                        points_checked, m_axis_tuser, want_pixel.done));
                end
                points_checked++;
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_pixels(s_axis_tuser, s_axis_tdata);
            outstanding <= expected_pixels.size();
            drawing     <= (phase != emr_pkg::PH_IDLE);
        end
    end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// tb_top: stimulus and verdict for the midpoint ellipse rasterizer
// drives start and advance words, throttles both sides; emr_checker predicts and compares
module tb_top;

    localparam int RB   = emr_pkg::RADIUS_BITS_DEF;
    localparam int CB   = emr_pkg::COORD_BITS_DEF;
    localparam int IN_W  = ((2*RB+2*CB+7)/8)*8;
    localparam int OUT_W = ((2*CB+2+7)/8)*8;

    localparam int WORD_TARGET      = 280;
    localparam int CALM_WORDS       = 50;
    localparam int SINK_HOLD_CYCLES = 120;
    localparam int TAIL_CYCLES      = 30;
    localparam int WATCHDOG_LIMIT   = 2000;

    logic            clk = 1'b0;
    logic            rst_n;
    logic            s_axis_tvalid;
    logic            s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata;
    logic            s_axis_tuser;
    logic            m_axis_tvalid;
    logic            m_axis_tready;
    logic [OUT_W-1:0] m_axis_tdata;
    logic            m_axis_tlast;
    logic            m_axis_tuser;

    int fail_count;
    int outstanding;
    int points_checked;
    int ellipses_done;
    bit drawing;

    bit idle_on       = 1'b1;
    int hold_requests = 0;
    int holds_served  = 0;
    int words_sent    = 0;
    int starts_sent   = 0;
    int quiet_cycles  = 0;

    always #5 clk = ~clk;

    midpoint_ellipse_rasterizer_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    emr_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tlast   (m_axis_tlast),
        .m_axis_tuser   (m_axis_tuser),
        .fail_count     (fail_count),
        .outstanding    (outstanding),
        .drawing        (drawing),
        .points_checked (points_checked),
        .ellipses_done  (ellipses_done)
    );

    function automatic logic [IN_W-1:0] pack_operands(input logic [RB-1:0] rx,
                                                      input logic [RB-1:0] ry,
                                                      input logic [CB-1:0] cx,
                                                      input logic [CB-1:0] cy);
        logic [IN_W-1:0] w;
        w                        = '0;
        w[RB-1:0]                = rx;
        w[2*RB-1:RB]             = ry;
        w[2*RB+CB-1:2*RB]        = cx;
        w[2*RB+2*CB-1:2*RB+CB]   = cy;
        return w;
    endfunction

    // mostly small radii so that ellipses finish quickly
    function automatic int pick_radius();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(0, 10);
        return $urandom_range(11, 40);
    endfunction

    // offer one word, with a random gap first while idling is on
    task automatic offer_word(input emr_pkg::cmd_kind_t kind, input logic [IN_W-1:0] payload);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= payload;
        s_axis_tuser  <= kind;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        words_sent++;
        if (kind == emr_pkg::CMD_START)
            starts_sent++;
    endtask

    // advance word, the operand fields carry junk that must be ignored
    task automatic offer_advance();
        offer_word(emr_pkg::CMD_STEP, pack_operands(RB'($urandom), RB'($urandom),
                                                    CB'($urandom), CB'($urandom)));
    endtask

    task automatic offer_start(input int rx, input int ry, input int cx, input int cy);
        offer_word(emr_pkg::CMD_START, pack_operands(RB'(rx), RB'(ry), CB'(cx), CB'(cy)));
    endtask

    // start, then advance until the ellipse is complete
    task automatic draw_ellipse(input int rx, input int ry, input int cx, input int cy);
        offer_start(rx, ry, cx, cy);
        offer_advance();
        while (drawing)
            offer_advance();
    endtask

    // stop sending until every expected point has come out
    task automatic drain_pause();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // output side: random stalls, plus one long hold on request
    initial
    begin : sink
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_served)
            begin
                holds_served++;
                m_axis_tready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 9) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_top: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial
    begin : stimulus
        int rx;
        int ry;
        int pick;
        int n;
        bit hold_done;
        bit pause_done;
        bit saved_idle;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        rst_n          = 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= emr_pkg::CMD_START;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // advance words with nothing to draw are ignored
        offer_advance();
        offer_advance();
        // zero radii: top point, then the transition point closes the ellipse
        draw_ellipse(0, 0, 0, 0);
        // largest radii at the corners of the centre range, left unfinished
        offer_start(1023, 1023, -2048, 2047);
        repeat (3) offer_advance();
        // start while drawing; zero width goes from the transition into region two
        draw_ellipse(0, 3, 2047, -2048);
        // zero height ends at the transition point
        draw_ellipse(1023, 0, -1, -1);
        drain_pause();
        draw_ellipse(2, 3, -5, 7);

        // random ellipses, some cut short, some stray advances
        while (words_sent < WORD_TARGET)
        begin
            if (words_sent >= WORD_TARGET - CALM_WORDS)
                idle_on = 1'b0;
            rx   = pick_radius();
            ry   = pick_radius();
            pick = $urandom_range(0, 19);
            if (!hold_done && words_sent >= 110)
            begin
                // long output hold while words keep coming, so the input side stalls
                hold_done  = 1'b1;
                saved_idle = idle_on;
                idle_on    = 1'b0;
                hold_requests++;
                draw_ellipse(20, 20, $urandom_range(0, 4095), $urandom_range(0, 4095));
                idle_on = saved_idle;
            end
            else if (!pause_done && words_sent >= 190)
            begin
                pause_done = 1'b1;
                drain_pause();
            end
            else if (pick == 0)
                offer_advance();
            else if (pick <= 3)
            begin
                n = $urandom_range(1, rx + ry + 1);
                offer_start(rx, ry, $urandom_range(0, 4095), $urandom_range(0, 4095));
                repeat (n) offer_advance();
            end
            else
                draw_ellipse(rx, ry, $urandom_range(0, 4095), $urandom_range(0, 4095));
        end

        idle_on = 1'b0;
        drain_pause();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("tb_top: run covered %0d input words including %0d starts", words_sent,
                 starts_sent);
        $display("tb_top: %0d points checked, %0d ellipses drawn to the end", points_checked,
                 ellipses_done);
        if (fail_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
